/* hdl/spq_pkg.sv */
// Package for the sorted priority queue: operation and status codes and
// the command/status structs between controller and datapath. No dependencies.
package spq_pkg;
  localparam logic [1:0] OP_INSERT   = 2'd0;
  localparam logic [1:0] OP_EXTRACT  = 2'd1;
  localparam logic [1:0] OP_DECREASE = 2'd2;
  localparam logic [1:0] OP_CONTAINS = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_NOTLOWER = 3'd4;

  typedef struct packed {
    logic load;     // capture request operands
    logic execute;  // apply the operation to the cell array
  } cmd_t;

  typedef struct packed {
    logic is_full;
    logic is_empty;
  } stat_t;
endpackage

/* hdl/spq_datapath.sv */
// Datapath of the sorted priority queue: a row of (id, weight) cells that
// compare in parallel and shift. Uses spq_pkg.
module spq_datapath #(
  parameter int CAPACITY    = 64,
  parameter int ID_BITS     = 16,
  parameter int WEIGHT_BITS = 32,
  parameter int CNT_BITS    = 7
) (
  input  logic                   clk,
  input  logic                   rst,
  input  spq_pkg::cmd_t          cmd,
  output spq_pkg::stat_t         stat,
  input  logic [1:0]             op_in,
  input  logic [ID_BITS-1:0]     id_in,
  input  logic [WEIGHT_BITS-1:0] wt_in,
  output logic [2:0]             res_status,
  output logic [ID_BITS-1:0]     res_id,
  output logic [WEIGHT_BITS-1:0] res_weight,
  output logic                   res_found,
  output logic [CNT_BITS-1:0]    res_count
);
  logic [ID_BITS-1:0]     ids [CAPACITY];
  logic [WEIGHT_BITS-1:0] wts [CAPACITY];
  logic [CNT_BITS-1:0]    occupancy;
  logic [1:0]             op;
  logic [ID_BITS-1:0]     id;
  logic [WEIGHT_BITS-1:0] wt;

  // Per-cell flags, all evaluated in parallel.
  logic [CAPACITY-1:0] valid, match, first, le_new, gt_new, prior_match;
  logic [CAPACITY-1:0] le_prev, gt_prev;
  logic [CAPACITY-1:0] upd_shift, upd_take;
  logic [CAPACITY-1:0] ins_take, ins_shift;
  logic                any_match, not_lower;
  logic [WEIGHT_BITS-1:0] match_wt;

  always_comb begin
    any_match = 1'b0;
    match_wt  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      valid[i]       = (CNT_BITS'(i) < occupancy);
      match[i]       = valid[i] && (ids[i] == id);
      le_new[i]      = valid[i] && (wts[i] <= wt);
      gt_new[i]      = valid[i] && (wts[i] > wt);
      prior_match[i] = any_match;
      first[i]       = match[i] && !any_match;
      if (first[i]) match_wt = wts[i];
      any_match      = any_match | match[i];
    end
    not_lower = any_match && (wt > match_wt);
    // Flags of the neighbor in front of each cell; the front cell sees a
    // smaller weight ahead of it.
    le_prev = {le_new[CAPACITY-2:0], 1'b1};
    gt_prev = {gt_new[CAPACITY-2:0], 1'b0};
    for (int i = 0; i < CAPACITY; i++) begin
      // Insert: the new entry lands at the first cell not <= new weight.
      ins_take[i]  = !le_new[i] && le_prev[i];
      ins_shift[i] = !le_prev[i];
      // Decrease: cells from the first larger weight up to the match move
      // back one, and the updated entry lands in the front-most of them.
      upd_shift[i] = gt_prev[i] && !prior_match[i];
      upd_take[i]  = !prior_match[i] && !gt_prev[i] && (gt_new[i] || first[i]);
    end
  end

  assign stat.is_full  = (occupancy == CNT_BITS'(CAPACITY));
  assign stat.is_empty = (occupancy == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= op_in;
      id <= id_in;
      wt <= wt_in;
    end
    if (cmd.execute) begin
      res_id     <= '0;
      res_weight <= '0;
      res_found  <= 1'b0;
      res_status <= spq_pkg::ST_OK;
      unique case (op)
        spq_pkg::OP_INSERT: begin
          if (stat.is_full) res_status <= spq_pkg::ST_FULL;
          else begin
            for (int i = 0; i < CAPACITY; i++) begin
              if (ins_take[i]) begin
                ids[i] <= id;
                wts[i] <= wt;
              end
            end
            for (int i = 1; i < CAPACITY; i++) begin
              if (ins_shift[i]) begin
                ids[i] <= ids[i-1];
                wts[i] <= wts[i-1];
              end
            end
          end
        end
        spq_pkg::OP_EXTRACT: begin
          if (stat.is_empty) res_status <= spq_pkg::ST_EMPTY;
          else begin
            res_id     <= ids[0];
            res_weight <= wts[0];
            for (int i = 0; i + 1 < CAPACITY; i++) begin
              ids[i] <= ids[i+1];
              wts[i] <= wts[i+1];
            end
          end
        end
        spq_pkg::OP_DECREASE: begin
          if (!any_match) res_status <= spq_pkg::ST_NOTFOUND;
          else if (not_lower) res_status <= spq_pkg::ST_NOTLOWER;
          else begin
            for (int i = 0; i < CAPACITY; i++) begin
              if (upd_take[i]) begin
                ids[i] <= id;
                wts[i] <= wt;
              end
            end
            for (int i = 1; i < CAPACITY; i++) begin
              if (upd_shift[i]) begin
                ids[i] <= ids[i-1];
                wts[i] <= wts[i-1];
              end
            end
          end
        end
        default: res_found <= any_match;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
      res_count <= '0;
    end else if (cmd.execute) begin
      if (op == spq_pkg::OP_INSERT && !stat.is_full) begin
        occupancy <= occupancy + 1'b1;
        res_count <= occupancy + 1'b1;
      end else if (op == spq_pkg::OP_EXTRACT && !stat.is_empty) begin
        occupancy <= occupancy - 1'b1;
        res_count <= occupancy - 1'b1;
      end else begin
        res_count <= occupancy;
      end
    end
  end

  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    occupancy <= CNT_BITS'(CAPACITY)) else $error("occupancy over capacity");
  a_occ_step: assert property (@(posedge clk) disable iff (rst)
    !$past(cmd.execute) && !$past(rst) |-> $stable(occupancy))
    else $error("occupancy moved idle");
  a_ext_dec: assert property (@(posedge clk) disable iff (rst)
    cmd.execute && op == spq_pkg::OP_EXTRACT && !stat.is_empty
    |=> occupancy == $past(occupancy) - 1'b1) else $error("extract count");
endmodule

/* hdl/spq_ctrl.sv */
// Controller of the sorted priority queue: request accept, execute and
// result handoff. Uses spq_pkg.
module spq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  output spq_pkg::cmd_t cmd
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state, state_next;

  assign s_tready    = (state == S_IDLE);
  assign m_tvalid    = (state == S_OUT);
  assign cmd.load    = s_tvalid && s_tready;
  assign cmd.execute = (state == S_EXEC);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (s_tvalid) state_next = S_EXEC;
      S_EXEC: state_next = S_OUT;
      S_OUT:  if (m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  a_exec_once: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |=> m_tvalid) else $error("result missing after execute");
  a_load_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.execute) else $error("execute missing after load");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid)) else $error("accept while result pending");
endmodule

/* hdl/sorted_priority_queue.sv */
// Sorted priority queue: one request in, one result out. An accepted request
// is executed as one parallel compare-and-shift across all cells into the
// result registers and then offered on the output; the next request can be
// accepted only once the result is taken, so a request occupies the block
// through the idle, execute and output states plus any wait for the result.
// Cells compare against the request in parallel, so time is independent of
// occupancy. Depends on spq_pkg, spq_ctrl and spq_datapath.
module sorted_priority_queue #(
  parameter int CAPACITY    = 64,
  parameter int ID_BITS     = 16,
  parameter int WEIGHT_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // opcode[1:0], node_id[ID_BITS-1:0], weight[WEIGHT_BITS-1:0], zero pad
  input  logic [((2+ID_BITS+WEIGHT_BITS+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // status[2:0], out_id, out_weight, found, is_empty, entry_count, zero pad
  output logic [((3+ID_BITS+WEIGHT_BITS+2+$clog2(CAPACITY+1)+7)/8)*8-1:0] m_tdata
);
  localparam int CNT_BITS = $clog2(CAPACITY + 1);
  localparam int OUT_USED = 3 + ID_BITS + WEIGHT_BITS + 2 + CNT_BITS;
  localparam int OUT_W    = ((OUT_USED + 7) / 8) * 8;

  spq_pkg::cmd_t          cmd;
  spq_pkg::stat_t         stat;
  logic [2:0]             res_status;
  logic [ID_BITS-1:0]     res_id;
  logic [WEIGHT_BITS-1:0] res_weight;
  logic                   res_found;
  logic [CNT_BITS-1:0]    res_count;

  spq_ctrl u_ctrl (
    .clk, .rst, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .cmd
  );

  spq_datapath #(
    .CAPACITY(CAPACITY), .ID_BITS(ID_BITS), .WEIGHT_BITS(WEIGHT_BITS),
    .CNT_BITS(CNT_BITS)
  ) u_dp (
    .clk, .rst, .cmd, .stat,
    .op_in (s_tdata[1:0]),
    .id_in (s_tdata[2 +: ID_BITS]),
    .wt_in (s_tdata[2+ID_BITS +: WEIGHT_BITS]),
    .res_status, .res_id, .res_weight, .res_found, .res_count
  );

  assign m_tdata = OUT_W'({res_count, (res_count == '0), res_found,
                           res_weight, res_id, res_status});

  logic unused_stat;
  assign unused_stat = stat.is_full ^ stat.is_empty;
endmodule

/* sim/tb_sorted_priority_queue.sv */
// Testbench for sorted_priority_queue: drives queue requests over the stream
// input, predicts each result with a behavioral queue and checks the output.
// Depends on spq_pkg and the sorted_priority_queue RTL.
module tb_sorted_priority_queue;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = 64;
  localparam int IW = 56;
  localparam int OW = 64;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] out_id;
    logic [31:0] out_weight;
    logic        found;
    logic        is_empty;
    logic [6:0]  entry_count;
  } result_t;

  class queue_scoreboard;
    logic [15:0] ids[$];
    logic [31:0] wts[$];
    result_t pending[$];
    int errors;

    function int find_id(logic [15:0] id);
      for (int i = 0; i < ids.size(); i++) if (ids[i] == id) return i;
      return -1;
    endfunction

    function void note_request(logic [1:0] op, logic [15:0] id, logic [31:0] wt);
      result_t r;
      int pos;
      r = '0;
      case (op)
        spq_pkg::OP_INSERT: begin
          if (ids.size() >= CAP) begin
            r.status = spq_pkg::ST_FULL;
          end else begin
            pos = 0;
            while (pos < wts.size() && wts[pos] <= wt) pos++;
            ids.insert(pos, id);
            wts.insert(pos, wt);
          end
        end
        spq_pkg::OP_EXTRACT: begin
          if (ids.size() == 0) begin
            r.status = spq_pkg::ST_EMPTY;
          end else begin
            r.out_id = ids.pop_front();
            r.out_weight = wts.pop_front();
          end
        end
        spq_pkg::OP_DECREASE: begin
          pos = find_id(id);
          if (pos < 0) r.status = spq_pkg::ST_NOTFOUND;
          else if (wt > wts[pos]) r.status = spq_pkg::ST_NOTLOWER;
          else begin
            ids.delete(pos);
            wts.delete(pos);
            // Move forward only past entries of strictly larger weight.
            while (pos > 0 && wts[pos-1] > wt) pos--;
            ids.insert(pos, id);
            wts.insert(pos, wt);
          end
        end
        default: r.found = (find_id(id) >= 0);
      endcase
      r.is_empty = (ids.size() == 0);
      r.entry_count = 7'(ids.size());
      pending.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t e;
      if (pending.size() == 0) begin
        $error("result with no request pending: %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status) begin
        $error("status expected %0d actual %0d", e.status, got.status); errors++;
      end
      if (got.out_id !== e.out_id) begin
        $error("out_id expected %0h actual %0h", e.out_id, got.out_id); errors++;
      end
      if (got.out_weight !== e.out_weight) begin
        $error("out_weight expected %0h actual %0h", e.out_weight, got.out_weight);
        errors++;
      end
      if (got.found !== e.found) begin
        $error("found expected %0d actual %0d", e.found, got.found); errors++;
      end
      if (got.is_empty !== e.is_empty) begin
        $error("is_empty expected %0d actual %0d", e.is_empty, got.is_empty); errors++;
      end
      if (got.entry_count !== e.entry_count) begin
        $error("entry_count expected %0d actual %0d", e.entry_count, got.entry_count);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [IW-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [OW-1:0] m_tdata;
  queue_scoreboard sb = new();
  int cycles = 0;
  bit sending_done = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  sorted_priority_queue u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  function automatic result_t unpack_result(logic [OW-1:0] d);
    result_t r;
    r.status = d[2:0];
    r.out_id = d[18:3];
    r.out_weight = d[50:19];
    r.found = d[51];
    r.is_empty = d[52];
    r.entry_count = d[59:53];
    return r;
  endfunction

  // Output side: random stall per result, checked at the accepting edge.
  initial begin
    int gap;
    @(posedge clk iff !rst);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        m_tready <= 0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1;
      @(posedge clk iff m_tvalid);
      sb.check_result(unpack_result(m_tdata));
    end
  end

  bit no_gaps = 0;

  task automatic send_request(logic [1:0] op, logic [15:0] id, logic [31:0] wt);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {6'b0, wt, id, op};
    @(posedge clk iff s_tready);
    sb.note_request(op, id, wt);
  endtask

  task automatic random_request();
    logic [1:0] op;
    logic [15:0] id;
    logic [31:0] wt;
    int n;
    n = sb.ids.size();
    op = 2'($urandom_range(0, 3));
    // Mostly reuse present ids and narrow weights so decreases and ties happen.
    if (n > 0 && $urandom_range(0, 3) != 0) id = sb.ids[$urandom_range(0, n - 1)];
    else id = ($urandom_range(0, 1)) ? 16'($urandom_range(0, 31)) : 16'($urandom);
    if ($urandom_range(0, 4) == 0) wt = $urandom;
    else wt = $urandom_range(0, 40);
    if (op == spq_pkg::OP_DECREASE && n > 0 && $urandom_range(0, 2) != 0) begin
      int p = sb.find_id(id);
      if (p >= 0) wt = sb.wts[p] - $urandom_range(0, 5 > sb.wts[p] ? sb.wts[p] : 5);
    end
    send_request(op, id, wt);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 0;
    // Directed: empty cases, extremes, ties, decreases, duplicates.
    send_request(spq_pkg::OP_EXTRACT, 16'h0, 32'h0);
    send_request(spq_pkg::OP_DECREASE, 16'h5, 32'h0);
    send_request(spq_pkg::OP_CONTAINS, 16'hFFFF, 32'h0);
    send_request(spq_pkg::OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(spq_pkg::OP_INSERT, 16'h0000, 32'h0);
    send_request(spq_pkg::OP_INSERT, 16'h0007, 32'd10);
    send_request(spq_pkg::OP_INSERT, 16'h0008, 32'd10);
    send_request(spq_pkg::OP_INSERT, 16'h0007, 32'd20);
    send_request(spq_pkg::OP_CONTAINS, 16'hFFFF, 32'h0);
    send_request(spq_pkg::OP_DECREASE, 16'h0007, 32'd11);
    send_request(spq_pkg::OP_DECREASE, 16'h0007, 32'd10);
    send_request(spq_pkg::OP_DECREASE, 16'hFFFF, 32'd10);
    send_request(spq_pkg::OP_DECREASE, 16'h0008, 32'd0);
    send_request(spq_pkg::OP_DECREASE, 16'h1234, 32'd0);
    repeat (8) send_request(spq_pkg::OP_EXTRACT, 16'h0, 32'h0);
    // Fill past capacity for the full case, then drain.
    no_gaps = 1;
    repeat (CAP + 3) send_request(spq_pkg::OP_INSERT, 16'($urandom),
                                  $urandom_range(0, 9));
    repeat (CAP + 2) send_request(spq_pkg::OP_EXTRACT, 16'($urandom), $urandom);
    no_gaps = 0;
    // Hold off until the queue of expected results drains.
    s_tvalid <= 0;
    wait (sb.pending.size() == 0);
    @(posedge clk);
    for (int i = 0; i < 1700; i++) begin
      no_gaps = (i % 300) < 60;
      random_request();
    end
    s_tvalid <= 0;
    sending_done = 1;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (sending_done && sb.pending.size() == 0) begin
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
      end
      if (cycles > 400000) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end
endmodule
